### rtl/gqa_pkg.sv
// ----------------------------------------------------------------------------
// gqa_pkg
// Shared constants, codes and fixed-point helpers of the quadrature
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package gqa_pkg;

  localparam int MAX_TEST_DOFS  = 8;
  localparam int MAX_TRIAL_DOFS = 8;
  localparam int MAX_POINTS     = 16;
  localparam int MAX_COMPONENTS = 4;

  localparam int PT_W   = 4;
  localparam int COMP_W = 2;
  localparam int DOF_W  = 3;
  localparam int VAL_W  = 32;
  localparam int JAC_W  = 31;
  localparam int ACC_W  = 40;
  localparam int PROD_W = 65;   // 33 x 32 signed product
  localparam int SH_W   = 49;   // product after >>> 16
  localparam int WIDE_W = 51;   // headroom for sums before saturation

  localparam int STORE_DEPTH = MAX_TEST_DOFS * MAX_COMPONENTS * MAX_POINTS;
  localparam int FAC_DEPTH   = MAX_POINTS;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [1:0] REQ_FACTOR  = 2'd0;
  localparam logic [1:0] REQ_TEST    = 2'd1;
  localparam logic [1:0] REQ_TRIAL   = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_TEST_DOFS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIAL_DOFS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_POINTS     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPONENTS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CONJUGATE  = 3'd4;

  localparam logic signed [WIDE_W-1:0] S32_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] S32_MIN = -WIDE_W'(64'sd2147483648);
  localparam logic signed [WIDE_W-1:0] S40_MAX = WIDE_W'(64'sd549755813887);
  localparam logic signed [WIDE_W-1:0] S40_MIN = -WIDE_W'(64'sd549755813888);

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    if (x > S32_MAX) return S32_MAX[VAL_W-1:0];
    if (x < S32_MIN) return S32_MIN[VAL_W-1:0];
    return x[VAL_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [WIDE_W-1:0] x);
    if (x > S40_MAX) return S40_MAX[ACC_W-1:0];
    if (x < S40_MIN) return S40_MIN[ACC_W-1:0];
    return x[ACC_W-1:0];
  endfunction

  // floor(p / 2^16), widened
  function automatic logic signed [WIDE_W-1:0] qsh(input logic signed [PROD_W-1:0] p);
    logic signed [SH_W-1:0] s;
    s = p[PROD_W-1:16];
    return WIDE_W'(s);
  endfunction

endpackage

`default_nettype wire

### rtl/gqa_ram.sv
// ----------------------------------------------------------------------------
// gqa_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gqa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/galerkin_quadrature_accumulator.sv
// ----------------------------------------------------------------------------
// galerkin_quadrature_accumulator
// Complex weighted quadrature accumulator for local Galerkin integrals.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the request kind, tdata the load fields.
// Test and trial value loads are written in the cycle they are accepted, so
// they stream at one item per cycle while the sequencer is idle. A point
// factor load runs the kernel through three Q16.16 scalings on the shared
// multiplier, input not ready meanwhile. A compute request walks every
// (row, col) entry; each term of point_count*component_count runs the one
// complex MAC sequence (a 33x32 multiplier reused for all eight real
// products), and each entry ends with a load of the output register.
// Entries leave row by row on m_*, tlast on the final one; the input is
// ready again once the final entry sits in the output register.
// A stalled receiver holds the entry in the output register and the
// sequencer waits to emit the next entry. Config writes (cfg_*) are always
// taken; they belong in idle periods. Reset restores all count registers to
// one and conjugation on; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module galerkin_quadrature_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // point[3:0] component[5:4] dof[8:6] value_re[40:9] value_im[72:41]
  // jacobian_test[103:73] jacobian_trial[134:104] quad_weight[165:135]
  input  wire logic [gqa_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                        s_tuser,
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // row[2:0] col[5:3] sum_re[45:6] sum_im[85:46]
  output      logic [gqa_pkg::OUT_DATA_W-1:0]    m_tdata,
  output      logic                              m_tlast,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [gqa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [gqa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import gqa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FAC, ST_MAC, ST_EMIT} state_t;

  localparam logic [3:0] FAC_LAST = 4'd7;
  localparam logic [3:0] MAC_LAST = 4'd9;

  state_t state;
  logic [3:0] step;

  logic [3:0] test_dofs, trial_dofs;
  logic [4:0] points;
  logic [2:0] comps;
  logic       conj;

  logic [DOF_W-1:0]  lr, lc, r, c;
  logic [PT_W-1:0]   lp, p, fpt;
  logic [COMP_W-1:0] lk, k;

  logic signed [VAL_W-1:0] xr, xi, are, aim;
  logic [JAC_W-1:0]        jt, jr, jw;
  logic signed [SH_W-1:0]  t0;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [PROD_W-1:0] prod;

  logic signed [32:0]      mul_a;
  logic signed [VAL_W-1:0] mul_b;

  logic [PT_W-1:0]         in_pt;
  logic [COMP_W-1:0]       in_comp;
  logic [DOF_W-1:0]        in_dof;
  logic [VAL_W-1:0]        in_re, in_im;
  logic                    in_acc;

  logic [2*VAL_W-1:0] fac_rd, test_rd, trial_rd;
  logic               test_we, trial_we, fac_we, rd_en;
  logic signed [VAL_W-1:0] tr, ti, ur, ui, fre, fim;
  logic signed [32:0]      tim;
  logic signed [WIDE_W-1:0] sh, acc_re_next, acc_im_next;
  logic out_load, emit_last, term_last;

  assign in_pt   = s_tdata[3:0];
  assign in_comp = s_tdata[5:4];
  assign in_dof  = s_tdata[8:6];
  assign in_re   = s_tdata[40:9];
  assign in_im   = s_tdata[72:41];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  assign test_we  = in_acc && (s_tuser == REQ_TEST);
  assign trial_we = in_acc && (s_tuser == REQ_TRIAL);
  assign fac_we   = (state == ST_FAC) && (step == FAC_LAST);
  assign rd_en    = (state == ST_MAC) && (step == 4'd0);

  gqa_ram #(.WIDTH(2*VAL_W), .DEPTH(FAC_DEPTH)) u_fac (
    .clk, .we(fac_we), .waddr(fpt), .wdata({xi, xr}),
    .re(rd_en), .raddr(p), .rdata(fac_rd)
  );
  gqa_ram #(.WIDTH(2*VAL_W), .DEPTH(STORE_DEPTH)) u_test (
    .clk, .we(test_we), .waddr({in_dof, in_comp, in_pt}), .wdata({in_im, in_re}),
    .re(rd_en), .raddr({r, k, p}), .rdata(test_rd)
  );
  gqa_ram #(.WIDTH(2*VAL_W), .DEPTH(STORE_DEPTH)) u_trial (
    .clk, .we(trial_we), .waddr({in_dof, in_comp, in_pt}), .wdata({in_im, in_re}),
    .re(rd_en), .raddr({c, k, p}), .rdata(trial_rd)
  );

  assign tr  = test_rd[VAL_W-1:0];
  assign ti  = test_rd[2*VAL_W-1:VAL_W];
  assign ur  = trial_rd[VAL_W-1:0];
  assign ui  = trial_rd[2*VAL_W-1:VAL_W];
  assign fre = fac_rd[VAL_W-1:0];
  assign fim = fac_rd[2*VAL_W-1:VAL_W];
  assign tim = conj ? -33'(ti) : 33'(ti);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 33'(xr);
    mul_b = $signed({1'b0, jt});
    if (state == ST_FAC) begin
      mul_a = step[0] ? 33'(xi) : 33'(xr);
      case (step[2:1])
        2'd0:    mul_b = $signed({1'b0, jt});
        2'd1:    mul_b = $signed({1'b0, jr});
        default: mul_b = $signed({1'b0, jw});
      endcase
    end else begin
      case (step)
        4'd1:    begin mul_a = 33'(tr);  mul_b = ur;  end
        4'd2:    begin mul_a = tim;      mul_b = ui;  end
        4'd3:    begin mul_a = 33'(tr);  mul_b = ui;  end
        4'd4:    begin mul_a = tim;      mul_b = ur;  end
        4'd5:    begin mul_a = 33'(are); mul_b = fre; end
        4'd6:    begin mul_a = 33'(aim); mul_b = fim; end
        4'd7:    begin mul_a = 33'(are); mul_b = fim; end
        default: begin mul_a = 33'(aim); mul_b = fre; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign sh          = qsh(prod);
  assign acc_re_next = WIDE_W'(acc_re) + WIDE_W'(t0) - sh;
  assign acc_im_next = WIDE_W'(acc_im) + WIDE_W'(t0) + sh;
  assign term_last   = (p == lp) && (k == lk);
  assign emit_last   = (r == lr) && (c == lc);
  assign out_load    = (state == ST_EMIT) && (!m_tvalid || m_tready);

  function automatic logic [3:0] last_idx(input logic [4:0] v, input logic [4:0] maxv);
    if (v == 5'd0) return 4'd0;
    if (v > maxv)  return 4'(maxv - 5'd1);
    return 4'(v - 5'd1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      m_tvalid   <= 1'b0;
      test_dofs  <= 4'd1;
      trial_dofs <= 4'd1;
      points     <= 5'd1;
      comps      <= 3'd1;
      conj       <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_TEST_DOFS:  test_dofs  <= cfg_data[3:0];
          REG_TRIAL_DOFS: trial_dofs <= cfg_data[3:0];
          REG_POINTS:     points     <= cfg_data;
          REG_COMPONENTS: comps      <= cfg_data[2:0];
          REG_CONJUGATE:  conj       <= cfg_data[0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          step <= '0;
          if (in_acc && s_tuser == REQ_FACTOR) begin
            xr    <= $signed(in_re);
            xi    <= $signed(in_im);
            jt    <= s_tdata[103:73];
            jr    <= s_tdata[134:104];
            jw    <= s_tdata[165:135];
            fpt   <= in_pt;
            state <= ST_FAC;
          end else if (in_acc && s_tuser == REQ_COMPUTE) begin
            lr     <= DOF_W'(last_idx({1'b0, test_dofs}, 5'(MAX_TEST_DOFS)));
            lc     <= DOF_W'(last_idx({1'b0, trial_dofs}, 5'(MAX_TRIAL_DOFS)));
            lp     <= PT_W'(last_idx(points, 5'(MAX_POINTS)));
            lk     <= COMP_W'(last_idx({2'b0, comps}, 5'(MAX_COMPONENTS)));
            r      <= '0;
            c      <= '0;
            p      <= '0;
            k      <= '0;
            acc_re <= '0;
            acc_im <= '0;
            state  <= ST_MAC;
          end
        end
        ST_FAC: begin
          step <= step + 4'd1;
          if (step != 4'd0 && step != FAC_LAST) begin
            if (step[0]) xr <= sat32(sh);
            else         xi <= sat32(sh);
          end
          if (step == FAC_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_MAC: begin
          step <= (step == MAC_LAST) ? 4'd0 : step + 4'd1;
          case (step)
            4'd2, 4'd4, 4'd6, 4'd8: t0 <= sh[SH_W-1:0];
            4'd3: are <= sat32(WIDE_W'(t0) - sh);
            4'd5: aim <= sat32(WIDE_W'(t0) + sh);
            4'd7: acc_re <= sat40(acc_re_next);
            4'd9: begin
              acc_im <= sat40(acc_im_next);
              if (term_last) begin
                state <= ST_EMIT;
              end else if (k == lk) begin
                k <= '0;
                p <= p + 1'b1;
              end else begin
                k <= k + 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_EMIT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b0, acc_im, acc_re, c, r};
            m_tlast  <= emit_last;
            acc_re   <= '0;
            acc_im   <= '0;
            p        <= '0;
            k        <= '0;
            step     <= '0;
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_MAC;
              if (c == lc) begin
                c <= '0;
                r <= r + 1'b1;
              end else begin
                c <= c + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && emit_last |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after the final entry");

  a_mac_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC |-> step <= MAC_LAST)
    else $error("MAC step counter out of range");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_EMIT)
    else $error("output item raised outside the emit state");

  a_fac_busy: assert property (@(posedge clk) disable iff (rst)
    fac_we |=> s_tready)
    else $error("point factor load did not release the input");

endmodule

`default_nettype wire
